[sv/mbrm_pkg.sv]
// shared types, constants and codes for the modbus rtu register read master
package mbrm_pkg;

    localparam int MaxRegisters = 64;
    localparam int BufAw = $clog2(MaxRegisters);
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_FAIL = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] KIND_REQ = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_COUNT = 3'd1;
    localparam logic [2:0] ST_TRANSPORT = 3'd2;
    localparam logic [2:0] ST_CRC = 3'd3;
    localparam logic [2:0] ST_HEADER = 3'd4;

    localparam logic [1:0] CFG_SLAVE = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_RETRY = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] function_code;
        logic [15:0] reg_address;
        logic [6:0] reg_count;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [15:0] value;
        logic [2:0] status;
        logic last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB,
        S_REQ_CRC,
        S_REQ_OUT,
        S_WAIT,
        S_RX_CRC,
        S_CHECK,
        S_WORD_RD,
        S_WORD_OUT,
        S_FAIL_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } crc_ctl_t;

endpackage

[sv/mbrm_crc.sv]
// bit-serial crc-16 unit, one bit per cycle over a byte
module mbrm_crc
    import mbrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  crc_ctl_t ctl,
    input  logic init,
    input  logic [7:0] data,
    output logic done,
    output logic [15:0] crc
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0] sh_reg, sh_next;
    logic [3:0] cnt_reg, cnt_next;
    logic fb;

    assign fb = crc_reg[0] ^ sh_reg[0];

    always_comb
    begin
        crc_next = crc_reg;
        sh_next = sh_reg;
        cnt_next = cnt_reg;
        if (init)
        begin
            crc_next = CrcInit;
        end
        if (ctl.start)
        begin
            sh_next = data;
            cnt_next = 4'd8;
        end
        else if (cnt_reg != 4'd0)
        begin
            crc_next = fb ? ((crc_reg >> 1) ^ CrcPoly) : (crc_reg >> 1);
            sh_next = sh_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CrcInit;
            cnt_reg <= 4'd0;
            sh_reg <= 8'd0;
        end
        else
        begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
            sh_reg <= sh_next;
        end
    end

    assign done = (cnt_reg == 4'd0);
    assign crc = crc_reg;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 4'd8)
        else $error("crc bit counter out of range");
    a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> cnt_reg == 4'd8)
        else $error("crc start did not load counter");
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 4'd0 && !ctl.start) |=> cnt_reg == $past(cnt_reg) - 4'd1)
        else $error("crc counter did not step");
`endif

endmodule

[sv/modbus_rtu_register_read_master_core.sv]
// modbus rtu register read master: request build, response check, word output
// One item is taken at a time. Each response byte before the two CRC bytes
// passes through the serial CRC unit, which updates one bit per cycle,
// before the next byte is taken. A start applies its offset in S_SUB, then
// the six request bytes pass through that same unit; the eight request bytes
// then go out one per transfer. A retry passes the six request bytes through
// the unit again before the request is sent again. On success each register
// word is read from the internal 64-entry buffer in S_WORD_RD and sent in
// S_WORD_OUT, in order, the last one marked. Output transfers wait on stall.
module modbus_rtu_register_read_master_core
    import mbrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  in_item_t in_data,
    output logic out_valid,
    input  logic out_stall,
    output out_item_t out_data
);

    logic [7:0] slave_reg;
    logic [15:0] offset_reg;
    logic [7:0] retry_reg;

    state_t state_reg, state_next;
    logic [7:0] func_reg, func_next;
    logic [15:0] start_reg, start_next;
    logic [6:0] count_reg, count_next;
    logic [7:0] attempt_reg, attempt_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] crc_lo_reg, crc_lo_next;
    logic hdr_bad_reg, hdr_bad_next;
    logic [2:0] idx_reg, idx_next;
    logic [15:0] sub_reg, sub_next;
    logic [15:0] req_crc_reg, req_crc_next;
    logic [2:0] st_reg, st_next;
    logic [7:0] rxb_reg, rxb_next;
    logic [6:0] word_reg, word_next;

    logic [15:0] buf_mem [MaxRegisters];
    logic [15:0] rd_reg;
    logic buf_we;
    logic [BufAw-1:0] buf_addr;
    logic [15:0] buf_wdata;

    crc_ctl_t crc_ctl;
    logic crc_init, crc_done;
    logic [7:0] crc_data;
    logic [15:0] crc_val;

    logic take, emit;
    logic [7:0] req_byte;
    logic [7:0] total;
    logic [7:0] rpos;

    mbrm_crc u_crc (
        .clk(clk), .rst_n(rst_n), .ctl(crc_ctl), .init(crc_init),
        .data(crc_data), .done(crc_done), .crc(crc_val)
    );

    assign take = in_valid && !in_stall;
    assign emit = out_valid && !out_stall;
    assign total = 8'd5 + {count_reg, 1'b0};
    assign rpos = pos_reg - 8'd3;

    always_comb
    begin
        case (idx_reg)
            3'd0: req_byte = slave_reg;
            3'd1: req_byte = func_reg;
            3'd2: req_byte = start_reg[15:8];
            3'd3: req_byte = start_reg[7:0];
            3'd4: req_byte = 8'd0;
            3'd5: req_byte = {1'b0, count_reg};
            3'd6: req_byte = req_crc_reg[7:0];
            default: req_byte = req_crc_reg[15:8];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg <= 8'd1;
            offset_reg <= 16'd0;
            retry_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLAVE: slave_reg <= cfg_data[7:0];
                CFG_OFFSET: offset_reg <= cfg_data;
                CFG_RETRY: retry_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_addr] <= buf_wdata;
        end
        rd_reg <= buf_mem[buf_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_WAIT:
            begin
                if (take && in_data.command == CMD_START)
                begin
                    if (in_data.reg_count == 7'd0 || in_data.reg_count > 7'(MaxRegisters))
                        state_next = S_FAIL_OUT;
                    else
                        state_next = S_SUB;
                end
                else if (take && state_reg == S_WAIT && in_data.command == CMD_FAIL)
                begin
                    state_next = (attempt_reg < retry_reg) ? S_REQ_CRC : S_FAIL_OUT;
                end
                else if (take && state_reg == S_WAIT && in_data.command == CMD_BYTE)
                begin
                    if (pos_reg + 8'd2 < total)
                        state_next = S_RX_CRC;
                    else if (pos_reg + 8'd2 != total)
                        state_next = S_CHECK;
                end
            end
            S_SUB: state_next = S_REQ_CRC;
            S_REQ_CRC:
                if (crc_done && idx_reg == 3'd6) state_next = S_REQ_OUT;
            S_REQ_OUT:
                if (emit && idx_reg == 3'd7) state_next = S_WAIT;
            S_RX_CRC:
                if (crc_done) state_next = S_WAIT;
            S_CHECK:
            begin
                if (crc_val != {rxb_reg, crc_lo_reg} || hdr_bad_reg)
                    state_next = (attempt_reg < retry_reg) ? S_REQ_CRC : S_FAIL_OUT;
                else
                    state_next = S_WORD_RD;
            end
            S_WORD_RD: state_next = S_WORD_OUT;
            S_WORD_OUT:
                if (emit) state_next = (word_reg + 7'd1 == count_reg) ? S_IDLE : S_WORD_RD;
            S_FAIL_OUT:
                if (emit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        func_next = func_reg;
        start_next = start_reg;
        count_next = count_reg;
        attempt_next = attempt_reg;
        pos_next = pos_reg;
        crc_lo_next = crc_lo_reg;
        hdr_bad_next = hdr_bad_reg;
        idx_next = idx_reg;
        sub_next = sub_reg;
        req_crc_next = req_crc_reg;
        st_next = st_reg;
        rxb_next = rxb_reg;
        word_next = word_reg;
        in_stall = 1'b1;
        out_valid = 1'b0;
        out_data = '0;
        crc_ctl = '0;
        crc_init = 1'b0;
        crc_data = req_byte;
        buf_we = 1'b0;
        buf_addr = word_reg[BufAw-1:0];
        buf_wdata = {rxb_reg, 8'd0};
        case (state_reg)
            S_IDLE, S_WAIT:
            begin
                in_stall = 1'b0;
                if (take)
                begin
                    rxb_next = in_data.rx_byte;
                    if (in_data.command == CMD_START)
                    begin
                        func_next = in_data.function_code;
                        count_next = in_data.reg_count;
                        sub_next = in_data.reg_address;
                        start_next = in_data.reg_address - offset_reg;
                        attempt_next = 8'd0;
                        st_next = ST_COUNT;
                    end
                    else if (state_reg == S_WAIT && in_data.command == CMD_FAIL)
                    begin
                        st_next = ST_TRANSPORT;
                        if (attempt_reg < retry_reg)
                        begin
                            attempt_next = attempt_reg + 8'd1;
                            idx_next = 3'd0;
                            crc_init = 1'b1;
                        end
                    end
                    else if (state_reg == S_WAIT && in_data.command == CMD_BYTE)
                    begin
                        if (pos_reg + 8'd2 < total)
                        begin
                            crc_ctl.start = 1'b1;
                            crc_data = in_data.rx_byte;
                            if (pos_reg == 8'd0 && in_data.rx_byte != slave_reg)
                                hdr_bad_next = 1'b1;
                            if (pos_reg == 8'd1 && in_data.rx_byte != func_reg)
                                hdr_bad_next = 1'b1;
                            if (pos_reg == 8'd2 && in_data.rx_byte != {count_reg, 1'b0})
                                hdr_bad_next = 1'b1;
                            if (pos_reg > 8'd2)
                            begin
                                buf_addr = rpos[BufAw:1];
                                buf_we = 1'b1;
                                buf_wdata = rpos[0] ? {rd_reg[15:8], in_data.rx_byte}
                                                    : {in_data.rx_byte, 8'd0};
                            end
                        end
                        else if (pos_reg + 8'd2 == total)
                        begin
                            crc_lo_next = in_data.rx_byte;
                        end
                        pos_next = pos_reg + 8'd1;
                    end
                end
                else if (state_reg == S_WAIT && pos_reg > 8'd3)
                begin
                    // keep the high byte of the current word readable
                    buf_addr = rpos[BufAw:1];
                end
            end
            S_SUB:
            begin
                if (sub_reg < offset_reg) start_next = sub_reg;
                idx_next = 3'd0;
                crc_init = 1'b1;
            end
            S_REQ_CRC:
            begin
                if (crc_done)
                begin
                    if (idx_reg == 3'd6)
                    begin
                        req_crc_next = crc_val;
                        idx_next = 3'd0;
                    end
                    else
                    begin
                        crc_ctl.start = 1'b1;
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            S_REQ_OUT:
            begin
                out_valid = 1'b1;
                out_data.kind = KIND_REQ;
                out_data.value = {8'd0, req_byte};
                if (emit)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        pos_next = 8'd0;
                        crc_lo_next = 8'd0;
                        hdr_bad_next = 1'b0;
                        crc_init = 1'b1;
                    end
                end
            end
            S_RX_CRC:
            begin
                if (pos_reg > 8'd3) buf_addr = rpos[BufAw:1];
            end
            S_CHECK:
            begin
                word_next = 7'd0;
                buf_addr = '0;
                st_next = (crc_val != {rxb_reg, crc_lo_reg}) ? ST_CRC : ST_HEADER;
                if ((crc_val != {rxb_reg, crc_lo_reg} || hdr_bad_reg)
                    && attempt_reg < retry_reg)
                begin
                    attempt_next = attempt_reg + 8'd1;
                    idx_next = 3'd0;
                    crc_init = 1'b1;
                end
            end
            S_WORD_RD: ;
            S_WORD_OUT:
            begin
                out_valid = 1'b1;
                out_data.kind = KIND_WORD;
                out_data.value = rd_reg;
                out_data.last = (word_reg + 7'd1 == count_reg);
                if (emit)
                begin
                    word_next = word_reg + 7'd1;
                    buf_addr = word_next[BufAw-1:0];
                end
            end
            S_FAIL_OUT:
            begin
                out_valid = 1'b1;
                out_data.kind = KIND_FAIL;
                out_data.status = st_reg;
                out_data.last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            attempt_reg <= 8'd0;
            pos_reg <= 8'd0;
            hdr_bad_reg <= 1'b0;
            idx_reg <= 3'd0;
            word_reg <= 7'd0;
            count_reg <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            attempt_reg <= attempt_next;
            pos_reg <= pos_next;
            hdr_bad_reg <= hdr_bad_next;
            idx_reg <= idx_next;
            word_reg <= word_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        start_reg <= start_next;
        crc_lo_reg <= crc_lo_next;
        sub_reg <= sub_next;
        req_crc_reg <= req_crc_next;
        st_reg <= st_next;
        rxb_reg <= rxb_next;
    end

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_WAIT) |-> in_stall)
        else $error("input transfer while busy");
    a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REQ_OUT) |-> (attempt_reg == 8'd0 || attempt_reg <= retry_reg))
        else $error("attempt count above retry limit");
    a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WORD_OUT) |-> word_reg < count_reg)
        else $error("word index past count");
    a_fail_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FAIL_OUT && !out_stall) |=> state_reg == S_IDLE)
        else $error("failure transfer did not end run");
`endif

endmodule

[tb/tb_top.sv]
// testbench for the modbus rtu register read master: directed and random runs
`timescale 1ns / 1ps
module tb_top
    import mbrm_pkg::*;
();

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;

    modbus_rtu_register_read_master_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    localparam int CycleLimit = 1500000;

    // model state
    logic [7:0] m_slave;
    logic [15:0] m_offset;
    logic [7:0] m_retry;
    logic m_waiting;
    logic [7:0] m_func;
    logic [15:0] m_start_reg;
    logic [6:0] m_count;
    logic [7:0] m_attempt;
    logic [7:0] m_pos;
    logic [15:0] m_crc;
    logic [7:0] m_crc_low;
    logic m_hdr_bad;
    logic [15:0] m_words [MaxRegisters];

    out_item_t expected_q[$];
    int errors;
    int cycles;
    int n_items;
    int n_results;
    int n_words;
    int n_fails;
    bit quiet;
    bit done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int j = 0; j < 8; j++)
        begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [15:0] value, logic [2:0] status,
                                        logic last);
        out_item_t r;
        r.kind = kind;
        r.value = value;
        r.status = status;
        r.last = last;
        expected_q.push_back(r);
    endfunction

    function automatic void model_request();
        logic [7:0] req [8];
        logic [15:0] crc;
        req[0] = m_slave;
        req[1] = m_func;
        req[2] = m_start_reg[15:8];
        req[3] = m_start_reg[7:0];
        req[4] = 8'h00;
        req[5] = {1'b0, m_count};
        crc = CrcInit;
        for (int i = 0; i < 6; i++)
            crc = crc_update(crc, req[i]);
        req[6] = crc[7:0];
        req[7] = crc[15:8];
        for (int i = 0; i < 8; i++)
            push_result(KIND_REQ, {8'h00, req[i]}, ST_OK, 1'b0);
        m_waiting = 1'b1;
        m_pos = 8'd0;
        m_crc = CrcInit;
        m_crc_low = 8'd0;
        m_hdr_bad = 1'b0;
    endfunction

    function automatic void model_fail(logic [2:0] status);
        if (m_attempt < m_retry)
        begin
            m_attempt = m_attempt + 8'd1;
            model_request();
        end
        else
        begin
            m_waiting = 1'b0;
            push_result(KIND_FAIL, 16'h0000, status, 1'b1);
        end
    endfunction

    function automatic void predict_master(in_item_t it);
        int total;
        int r;
        if (it.command == CMD_START)
        begin
            if (it.reg_count == 0 || it.reg_count > MaxRegisters)
            begin
                m_waiting = 1'b0;
                push_result(KIND_FAIL, 16'h0000, ST_COUNT, 1'b1);
                return;
            end
            m_start_reg = (it.reg_address >= m_offset) ? it.reg_address - m_offset
                                                       : it.reg_address;
            m_func = it.function_code;
            m_count = it.reg_count;
            m_attempt = 8'd0;
            model_request();
            return;
        end
        if (!m_waiting || it.command == CMD_UNUSED)
            return;
        if (it.command == CMD_FAIL)
        begin
            model_fail(ST_TRANSPORT);
            return;
        end
        total = 5 + 2 * m_count;
        if (m_pos + 2 < total)
        begin
            m_crc = crc_update(m_crc, it.rx_byte);
            if (m_pos == 0)
            begin
                if (it.rx_byte != m_slave) m_hdr_bad = 1'b1;
            end
            else if (m_pos == 1)
            begin
                if (it.rx_byte != m_func) m_hdr_bad = 1'b1;
            end
            else if (m_pos == 2)
            begin
                if (it.rx_byte != 8'(2 * m_count)) m_hdr_bad = 1'b1;
            end
            else
            begin
                r = (m_pos - 3) >> 1;
                if (((m_pos - 3) & 1) == 0)
                    m_words[r] = {it.rx_byte, 8'h00};
                else
                    m_words[r][7:0] = it.rx_byte;
            end
            m_pos = m_pos + 8'd1;
            return;
        end
        if (m_pos + 2 == total)
        begin
            m_crc_low = it.rx_byte;
            m_pos = m_pos + 8'd1;
            return;
        end
        if (m_crc != {it.rx_byte, m_crc_low})
            model_fail(ST_CRC);
        else if (m_hdr_bad)
            model_fail(ST_HEADER);
        else
        begin
            m_waiting = 1'b0;
            for (int i = 0; i < m_count; i++)
                push_result(KIND_WORD, m_words[i], ST_OK, (i + 1 == m_count));
        end
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
    endtask

    // result checker and stall generator
    int stall_left;
    int run_left;
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected transfer", out_data.value, 16'h0);
            else
            begin
                e = expected_q.pop_front();
                if (out_data.kind != e.kind)
                    report_mismatch("kind", 16'(out_data.kind), 16'(e.kind));
                if (out_data.value != e.value)
                    report_mismatch("value", out_data.value, e.value);
                if (out_data.status != e.status)
                    report_mismatch("status", 16'(out_data.status), 16'(e.status));
                if (out_data.last != e.last)
                    report_mismatch("last", 16'(out_data.last), 16'(e.last));
                if (e.kind == KIND_WORD) n_words++;
                if (e.kind == KIND_FAIL) n_fails++;
            end
        end
        if (quiet || !rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (run_left > 0)
        begin
            run_left <= run_left - 1;
            out_stall <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(1, 12);
            else run_left <= $urandom_range(1, 40);
            out_stall <= 1'b0;
        end
    end

    // valid stays high after a transfer until the next item or an idle period
    task automatic send_item(in_item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_master(it);
        n_items++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SLAVE) m_slave = val[7:0];
        else if (idx == CFG_OFFSET) m_offset = val;
        else if (idx == CFG_RETRY) m_retry = val[7:0];
    endtask

    function automatic in_item_t make_item(logic [1:0] cmd, logic [7:0] fc, logic [15:0] addr,
                                           logic [6:0] cnt, logic [7:0] b);
        in_item_t it;
        it.command = cmd;
        it.function_code = fc;
        it.reg_address = addr;
        it.reg_count = cnt;
        it.rx_byte = b;
        return it;
    endfunction

    // response to the current request, optionally corrupted
    task automatic send_response(int corrupt);
        logic [7:0] bytes [$];
        logic [15:0] crc;
        bytes.push_back(m_slave);
        bytes.push_back(m_func);
        bytes.push_back(8'(2 * m_count));
        for (int i = 0; i < 2 * m_count; i++)
            bytes.push_back(8'($urandom));
        if (corrupt == 2) bytes[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
        crc = CrcInit;
        foreach (bytes[i]) crc = crc_update(crc, bytes[i]);
        bytes.push_back(crc[7:0]);
        bytes.push_back(crc[15:8]);
        if (corrupt == 1)
            bytes[$urandom_range(0, bytes.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        foreach (bytes[i]) send_item(make_item(CMD_BYTE, 8'($urandom), 16'($urandom),
                                               7'($urandom), bytes[i]));
    endtask

    task automatic start_read(logic [7:0] fc, logic [15:0] addr, logic [6:0] cnt);
        send_item(make_item(CMD_START, fc, addr, cnt, 8'($urandom)));
    endtask

    task automatic test_directed();
        start_read(8'h03, 16'h0000, 7'd1);
        send_response(0);
        start_read(8'hFF, 16'hFFFF, 7'd64);
        send_response(0);
        start_read(8'h04, 16'h1234, 7'd0);
        start_read(8'h04, 16'h1234, 7'd65);
        start_read(8'h04, 16'h1234, 7'd127);
        send_item(make_item(CMD_BYTE, 8'h00, 16'h0, 7'd0, 8'hFF));
        send_item(make_item(CMD_FAIL, 8'h00, 16'h0, 7'd0, 8'h00));
        send_item(make_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 7'd127, 8'hFF));
        start_read(8'h03, 16'h0010, 7'd2);
        send_item(make_item(CMD_FAIL, 8'h00, 16'h0, 7'd0, 8'h00));
        start_read(8'h03, 16'h0010, 7'd2);
        send_response(1);
        start_read(8'h03, 16'h0010, 7'd2);
        send_response(2);
        start_read(8'h03, 16'h0010, 7'd3);
        send_item(make_item(CMD_BYTE, 8'h00, 16'h0, 7'd0, m_slave));
        start_read(8'h03, 16'h0020, 7'd1);
        send_item(make_item(CMD_UNUSED, 8'h00, 16'h0, 7'd0, 8'h00));
        send_response(0);
    endtask

    task automatic test_offset_and_retry();
        write_reg(CFG_OFFSET, 16'h0100);
        write_reg(CFG_RETRY, 16'd2);
        write_reg(CFG_SLAVE, 16'h00F7);
        start_read(8'h03, 16'h0180, 7'd2);
        send_item(make_item(CMD_FAIL, 8'h00, 16'h0, 7'd0, 8'h00));
        send_response(1);
        send_response(0);
        start_read(8'h03, 16'h00FF, 7'd1);
        send_item(make_item(CMD_FAIL, 8'h00, 16'h0, 7'd0, 8'h00));
        send_item(make_item(CMD_FAIL, 8'h00, 16'h0, 7'd0, 8'h00));
        send_item(make_item(CMD_FAIL, 8'h00, 16'h0, 7'd0, 8'h00));
    endtask

    task automatic random_phase(int n_tx);
        int kind;
        for (int t = 0; t < n_tx; t++)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
                start_read(8'($urandom), 16'($urandom), 7'($urandom_range(65, 127)) & {7{1'b1}});
            else if (kind == 1)
                send_item(make_item(2'($urandom), 8'($urandom), 16'($urandom), 7'($urandom),
                                    8'($urandom)));
            else
            begin
                start_read(8'($urandom), 16'($urandom), 7'($urandom_range(1, 4)));
                for (int a = 0; a <= m_retry && a < 3 && m_waiting; a++)
                begin
                    if (kind == 2)
                        send_item(make_item(CMD_FAIL, 8'h0, 16'h0, 7'd0, 8'h0));
                    else if (kind == 3)
                        send_response(1);
                    else if (kind == 4)
                        send_response(2);
                    else if (kind == 5)
                        send_item(make_item(CMD_BYTE, 8'h0, 16'h0, 7'd0, 8'($urandom)));
                    else
                        send_response(0);
                end
            end
        end
    endtask

    task automatic test_random();
        random_phase(3);
        write_reg(CFG_SLAVE, 16'h0000);
        write_reg(CFG_OFFSET, 16'hFFFF);
        write_reg(CFG_RETRY, 16'd0);
        random_phase(2);
        write_reg(CFG_SLAVE, 16'h00FF);
        write_reg(CFG_OFFSET, 16'h8000);
        write_reg(CFG_RETRY, 16'd255);
        random_phase(2);
        write_reg(CFG_RETRY, 16'd1);
        write_reg(CFG_OFFSET, 16'($urandom));
        write_reg(CFG_SLAVE, 16'($urandom_range(0, 255)));
        random_phase(1);
        wait_idle();
        quiet = 1'b1;
        random_phase(2);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SLAVE;
        cfg_data = 16'h0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        m_slave = 8'd1;
        m_offset = 16'd0;
        m_retry = 8'd0;
        m_waiting = 1'b0;
        m_func = 8'd0;
        m_start_reg = 16'd0;
        m_count = 7'd0;
        m_attempt = 8'd0;
        m_pos = 8'd0;
        m_crc = CrcInit;
        m_crc_low = 8'd0;
        m_hdr_bad = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_offset_and_retry();
        test_random();
        wait_idle();
        $display("covered %0d input transfers and %0d results: %0d words, %0d failures",
                 n_items, n_results, n_words, n_fails);
        $display("settings included extreme slave ids, offsets and retry limits");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
